/* src/mwml_pkg.sv */
// Shared constants and codes for the mecanum wheel mixer with speed limiting.
// Register widths, reset values and configuration register indexes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mwml_pkg;

   localparam int SPEED_WIDTH_DEF = 16;

   // Limit register, gain register (unsigned Q4.8) and the gain's fraction bits
   localparam int LIMIT_W = 15;
   localparam int GAIN_W  = 12;
   localparam int FRAC_W  = 8;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 15;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 15'd8000;
   localparam logic [GAIN_W-1:0]  GAIN_RESET  = 12'd998;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MAX_WHEEL_SPEED = 2'd0,
      CSR_ROTATE_GAIN     = 2'd1
   } csr_index_type;

endpackage

`default_nettype wire

/* src/mecanum_wheel_mix_limit_core.sv */
// Mecanum wheel mixer: chassis velocity command in, four limited wheel speeds out.
// Depends on mwml_pkg for widths, register reset values and register indexes.
`timescale 1ns / 1ps
`default_nettype none

// Takes one chassis command per cycle (speed_x, speed_y, speed_turn) unless the
// output stalls, and returns four wheel speeds 2*(+-x +-y + gain*turn), truncated
// toward zero and saturated to the symmetric signed range. If the largest wheel
// magnitude exceeds max_wheel_speed, every wheel is rescaled to
// trunc(wheel*limit/largest) and was_scaled is set. The pipeline takes a new item
// every cycle unless the output stalls; its registers are, in order, mixing,
// saturation, magnitude search and the product wheel*limit, then a restoring divider
// that resolves one quotient bit per stage (the quotient never exceeds the 15-bit
// limit), then the output register. Every stage has its own valid bit and moves
// when the next stage is empty or moving, so bubbles collapse and a stalled output
// holds the rest of the pipe without loss. csr_ready is always high; write the
// registers only while no item is in flight.
module mecanum_wheel_mix_limit_core #(
   parameter int SPEED_WIDTH = mwml_pkg::SPEED_WIDTH_DEF,
   localparam int REQ_DATA_W = ((3 * SPEED_WIDTH + 7) / 8) * 8,
   localparam int RSP_DATA_W = ((4 * SPEED_WIDTH + 7) / 8) * 8
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // command items
   input  wire logic                               req_tvalid,
   output      logic                               req_tready,
   // speed_x, speed_y, speed_turn (SPEED_WIDTH each, signed), zero pad
   input  wire logic [REQ_DATA_W-1:0]              req_tdata,
   // wheel speed items
   output      logic                               rsp_tvalid,
   input  wire logic                               rsp_tready,
   // wheel_speed_0, wheel_speed_1, wheel_speed_2, wheel_speed_3 (signed), zero pad
   output      logic [RSP_DATA_W-1:0]              rsp_tdata,
   // was_scaled
   output      logic                               rsp_tuser,
   // register writes
   input  wire logic                               csr_valid,
   output      logic                               csr_ready,
   input  wire logic [mwml_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [mwml_pkg::CSR_DATA_W-1:0]    csr_data
);

   localparam int W         = SPEED_WIDTH;
   localparam int MW        = W - 1;                       // wheel magnitude
   localparam int LW        = mwml_pkg::LIMIT_W;
   localparam int GW        = mwml_pkg::GAIN_W;
   localparam int FW        = mwml_pkg::FRAC_W;
   localparam int BW        = W + 2;                       // +-x +-y, -x-y reaches 2^W
   localparam int TW        = W + GW + 1;                  // gain * turn
   localparam int QW        = W + GW + 2;                  // Q8 wheel sum
   localparam int PW        = MW + LW;                     // magnitude * limit
   localparam int DIV_STEPS = LW;
   localparam int NSTAGE    = 4 + DIV_STEPS + 1;
   localparam int RSP_STAGE = NSTAGE - 1;

   localparam logic signed [W-1:0]  SAT_HI   = {1'b0, {MW{1'b1}}};
   localparam logic signed [W-1:0]  MIN_CODE = {1'b1, {MW{1'b0}}};
   // 2*(q8/256) is q8/128; bias negatives so the shift truncates toward zero
   localparam int                   DIV_SH   = FW - 1;
   localparam logic signed [QW-1:0] TRUNC_BIAS = QW'((1 << DIV_SH) - 1);

   typedef struct packed {
      logic [3:0]          neg;
      logic [3:0][MW-1:0]  mag;
      logic [3:0][MW-1:0]  rem;
      logic [3:0][LW-1:0]  quo;
      logic [3:0][LW-1:0]  prod_lo;   // dividend bits not yet shifted in
      logic [MW-1:0]       divisor;
      logic                scaled;
   } div_type;

   // ---------------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------------
   logic [LW-1:0] limit_ff;
   logic [GW-1:0] gain_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= mwml_pkg::LIMIT_RESET;
         gain_ff  <= mwml_pkg::GAIN_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (mwml_pkg::csr_index_type'(csr_index))
            mwml_pkg::CSR_MAX_WHEEL_SPEED: limit_ff <= csr_data[LW-1:0];
            mwml_pkg::CSR_ROTATE_GAIN:     gain_ff  <= csr_data[GW-1:0];
            default: ;   // unknown index: drop the write
         endcase
      end
   end

   // ---------------------------------------------------------------------------
   // Pipeline control: a stage loads when it is empty or its successor loads
   // ---------------------------------------------------------------------------
   logic [NSTAGE-1:0] vld_ff;
   logic [NSTAGE-1:0] vld_in;
   logic [NSTAGE-1:0] load_en;

   always_comb begin
      load_en[RSP_STAGE] = !vld_ff[RSP_STAGE] || rsp_tready;
      for (int i = RSP_STAGE - 1; i >= 0; i--) begin
         load_en[i] = !vld_ff[i] || load_en[i+1];
      end
      for (int i = 0; i < NSTAGE; i++) begin
         if (load_en[i]) begin
            vld_in[i] = (i == 0) ? req_tvalid : vld_ff[(i == 0) ? 0 : i - 1];
         end else begin
            vld_in[i] = vld_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_tready = load_en[0];
   assign rsp_tvalid = vld_ff[RSP_STAGE];

   // ---------------------------------------------------------------------------
   // Stage 1: linear combinations of x and y, turn term gain*w
   // ---------------------------------------------------------------------------
   logic signed [W-1:0]  req_x, req_y, req_w;
   logic signed [BW-1:0] s1_base_in [4];
   logic signed [BW-1:0] s1_base_ff [4];
   logic signed [TW-1:0] s1_turn_in;
   logic signed [TW-1:0] s1_turn_ff;

   assign req_x = signed'(req_tdata[W-1:0]);
   assign req_y = signed'(req_tdata[2*W-1:W]);
   assign req_w = signed'(req_tdata[3*W-1:2*W]);

   always_comb begin
      s1_base_in[0] = BW'(req_y) - BW'(req_x);
      s1_base_in[1] = BW'(req_x) + BW'(req_y);
      s1_base_in[2] = BW'(req_x) - BW'(req_y);
      s1_base_in[3] = -BW'(req_x) - BW'(req_y);
      s1_turn_in    = TW'(signed'({1'b0, gain_ff})) * TW'(req_w);
   end

   always_ff @(posedge clock) begin
      if (load_en[0]) begin
         s1_base_ff <= s1_base_in;
         s1_turn_ff <= s1_turn_in;
      end
   end

   // ---------------------------------------------------------------------------
   // Stage 2: Q8 sum, halve-by-128 toward zero, saturate to +-SAT_HI
   // ---------------------------------------------------------------------------
   logic signed [W-1:0] s2_wheel_in [4];
   logic signed [W-1:0] s2_wheel_ff [4];

   always_comb begin
      logic signed [QW-1:0] q8;
      logic signed [QW-1:0] qt;
      for (int i = 0; i < 4; i++) begin
         q8 = (QW'(s1_base_ff[i]) <<< FW) + QW'(s1_turn_ff);
         qt = (q8 + (q8[QW-1] ? TRUNC_BIAS : QW'(0))) >>> DIV_SH;
         if (qt > QW'(SAT_HI)) begin
            s2_wheel_in[i] = SAT_HI;
         end else if (qt < -QW'(SAT_HI)) begin
            s2_wheel_in[i] = -SAT_HI;
         end else begin
            s2_wheel_in[i] = W'(qt);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load_en[1]) begin
         s2_wheel_ff <= s2_wheel_in;
      end
   end

   // ---------------------------------------------------------------------------
   // Stage 3: sign and magnitude, pairwise maximum
   // ---------------------------------------------------------------------------
   logic [3:0]    s3_neg_in, s3_neg_ff;
   logic [MW-1:0] s3_mag_in [4];
   logic [MW-1:0] s3_mag_ff [4];
   logic [MW-1:0] s3_pair_in [2];
   logic [MW-1:0] s3_pair_ff [2];

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         s3_neg_in[i] = s2_wheel_ff[i][W-1];
         s3_mag_in[i] = MW'(s2_wheel_ff[i][W-1] ? -s2_wheel_ff[i] : s2_wheel_ff[i]);
      end
      s3_pair_in[0] = (s3_mag_in[0] > s3_mag_in[1]) ? s3_mag_in[0] : s3_mag_in[1];
      s3_pair_in[1] = (s3_mag_in[2] > s3_mag_in[3]) ? s3_mag_in[2] : s3_mag_in[3];
   end

   always_ff @(posedge clock) begin
      if (load_en[2]) begin
         s3_neg_ff  <= s3_neg_in;
         s3_mag_ff  <= s3_mag_in;
         s3_pair_ff <= s3_pair_in;
      end
   end

   // ---------------------------------------------------------------------------
   // Stage 4: largest magnitude, limit compare, dividend magnitude*limit
   // ---------------------------------------------------------------------------
   div_type dv_ff [DIV_STEPS+1];
   div_type dv0_in;

   always_comb begin
      logic [MW-1:0] largest;
      logic [PW-1:0] prod;
      largest = (s3_pair_ff[0] > s3_pair_ff[1]) ? s3_pair_ff[0] : s3_pair_ff[1];
      dv0_in.neg     = s3_neg_ff;
      dv0_in.divisor = largest;
      dv0_in.scaled  = PW'(largest) > PW'(limit_ff);
      for (int i = 0; i < 4; i++) begin
         prod = PW'(s3_mag_ff[i]) * PW'(limit_ff);
         dv0_in.mag[i]     = s3_mag_ff[i];
         // Top bits stay below the divisor, so the quotient fits LW bits
         dv0_in.rem[i]     = prod[PW-1 -: MW];
         dv0_in.prod_lo[i] = prod[LW-1:0];
         dv0_in.quo[i]     = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_en[3]) begin
         dv_ff[0] <= dv0_in;
      end
   end

   // ---------------------------------------------------------------------------
   // Restoring divider: one quotient bit per stage for all four wheels
   // ---------------------------------------------------------------------------
   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
      div_type dstep_in;

      always_comb begin
         logic [W-1:0] sh;
         logic [W:0]   diff;
         dstep_in = dv_ff[k];
         for (int i = 0; i < 4; i++) begin
            sh   = {dv_ff[k].rem[i], dv_ff[k].prod_lo[i][LW-1]};
            diff = {1'b0, sh} - {2'b0, dv_ff[k].divisor};
            if (!diff[W]) begin
               dstep_in.rem[i] = diff[MW-1:0];
            end else begin
               dstep_in.rem[i] = sh[MW-1:0];
            end
            dstep_in.quo[i]     = {dv_ff[k].quo[i][LW-2:0], !diff[W]};
            dstep_in.prod_lo[i] = {dv_ff[k].prod_lo[i][LW-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (load_en[4+k]) begin
            dv_ff[k+1] <= dstep_in;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Output register: pick scaled or original magnitude, restore sign
   // ---------------------------------------------------------------------------
   logic signed [W-1:0] rsp_wheel_in [4];
   logic signed [W-1:0] rsp_wheel_ff [4];
   logic                rsp_scaled_ff;

   always_comb begin
      logic [MW-1:0] sel;
      for (int i = 0; i < 4; i++) begin
         sel = dv_ff[DIV_STEPS].scaled ? MW'(dv_ff[DIV_STEPS].quo[i])
                                       : dv_ff[DIV_STEPS].mag[i];
         rsp_wheel_in[i] = dv_ff[DIV_STEPS].neg[i] ? -W'(sel) : W'(sel);
      end
   end

   always_ff @(posedge clock) begin
      if (load_en[RSP_STAGE]) begin
         rsp_wheel_ff  <= rsp_wheel_in;
         rsp_scaled_ff <= dv_ff[DIV_STEPS].scaled;
      end
   end

   assign rsp_tdata = RSP_DATA_W'({rsp_wheel_ff[3], rsp_wheel_ff[2],
                                   rsp_wheel_ff[1], rsp_wheel_ff[0]});
   assign rsp_tuser = rsp_scaled_ff;

   // ---------------------------------------------------------------------------
   // Checks
   // ---------------------------------------------------------------------------
   a_stall_only_when_full : assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("input stalled while the output side can move");

   a_scaled_divisor : assert property (@(posedge clock) disable iff (reset)
      vld_ff[3] && dv_ff[0].scaled |-> dv_ff[0].divisor != '0)
      else $error("scaling requested with a zero largest magnitude");

   a_quotient_bound : assert property (@(posedge clock) disable iff (reset)
      vld_ff[RSP_STAGE-1] && dv_ff[DIV_STEPS].scaled |->
         dv_ff[DIV_STEPS].quo[0] <= dv_ff[DIV_STEPS].mag[0] &&
         dv_ff[DIV_STEPS].quo[1] <= dv_ff[DIV_STEPS].mag[1] &&
         dv_ff[DIV_STEPS].quo[2] <= dv_ff[DIV_STEPS].mag[2] &&
         dv_ff[DIV_STEPS].quo[3] <= dv_ff[DIV_STEPS].mag[3] &&
         dv_ff[DIV_STEPS].quo[0] <= limit_ff)
      else $error("scaled wheel grew past its own magnitude or the limit");

   a_no_min_code : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_wheel_ff[0] != MIN_CODE && rsp_wheel_ff[1] != MIN_CODE &&
                     rsp_wheel_ff[2] != MIN_CODE && rsp_wheel_ff[3] != MIN_CODE)
      else $error("wheel speed left the symmetric range");

endmodule

`default_nettype wire
